>>> rtl/csi_dec_pkg.sv
// ----------------------------------------------------------------------------
// csi_dec_pkg
// Shared types, character codes and key tables for the CSI escape decoder.
// ----------------------------------------------------------------------------
package csi_dec_pkg;

   localparam int unsigned NUM_FIELDS = 3;
   localparam int unsigned VALUE_W    = 32;

   localparam logic [1:0] PREFIX_NONE = 2'd0;
   localparam logic [1:0] PREFIX_LT   = 2'd1;
   localparam logic [1:0] PREFIX_QM   = 2'd2;
   localparam logic [1:0] PREFIX_GT   = 2'd3;

   localparam logic [1:0] FIELD_CNT_MAX = 2'd3;

   localparam logic [7:0] CH_LT    = 8'h3C;
   localparam logic [7:0] CH_QM    = 8'h3F;
   localparam logic [7:0] CH_GT    = 8'h3E;
   localparam logic [7:0] CH_SEMI  = 8'h3B;
   localparam logic [7:0] CH_MINUS = 8'h2D;
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_NINE  = 8'h39;
   localparam logic [7:0] CH_TILDE = 8'h7E;
   localparam logic [7:0] CH_UP_A  = 8'h41;
   localparam logic [7:0] CH_UP_B  = 8'h42;
   localparam logic [7:0] CH_UP_C  = 8'h43;
   localparam logic [7:0] CH_UP_D  = 8'h44;
   localparam logic [7:0] CH_UP_F  = 8'h46;
   localparam logic [7:0] CH_UP_H  = 8'h48;
   localparam logic [7:0] CH_UP_M  = 8'h4D;
   localparam logic [7:0] CH_LO_M  = 8'h6D;

   localparam logic [7:0] MOUSE_MOD_MASK = 8'h3C;

   localparam logic [35:0] POS_LIMIT = 36'h07FFFFFFF;
   localparam logic [35:0] NEG_LIMIT = 36'h080000000;

   localparam logic EVT_KEY   = 1'b0;
   localparam logic EVT_MOUSE = 1'b1;

   localparam logic [1:0] ACT_PRESS   = 2'd0;
   localparam logic [1:0] ACT_DRAG    = 2'd1;
   localparam logic [1:0] ACT_RELEASE = 2'd2;

   localparam logic [4:0] KEY_UNKNOWN = 5'd0;
   localparam logic [4:0] KEY_UP      = 5'd1;
   localparam logic [4:0] KEY_DOWN    = 5'd2;
   localparam logic [4:0] KEY_RIGHT   = 5'd3;
   localparam logic [4:0] KEY_LEFT    = 5'd4;
   localparam logic [4:0] KEY_HOME    = 5'd5;
   localparam logic [4:0] KEY_END     = 5'd6;
   localparam logic [4:0] KEY_INSERT  = 5'd7;
   localparam logic [4:0] KEY_DELETE  = 5'd8;
   localparam logic [4:0] KEY_PGUP    = 5'd9;
   localparam logic [4:0] KEY_PGDN    = 5'd10;
   localparam logic [4:0] KEY_F1      = 5'd11;
   localparam logic [4:0] KEY_F2      = 5'd12;
   localparam logic [4:0] KEY_F3      = 5'd13;
   localparam logic [4:0] KEY_F4      = 5'd14;
   localparam logic [4:0] KEY_F5      = 5'd15;
   localparam logic [4:0] KEY_F6      = 5'd16;
   localparam logic [4:0] KEY_F7      = 5'd17;
   localparam logic [4:0] KEY_F8      = 5'd18;
   localparam logic [4:0] KEY_F9      = 5'd19;
   localparam logic [4:0] KEY_F10     = 5'd20;
   localparam logic [4:0] KEY_F11     = 5'd21;
   localparam logic [4:0] KEY_F12     = 5'd22;

   typedef struct packed {
      logic                                 pending;
      logic [1:0]                           prefix;
      logic [1:0]                           count;
      logic [NUM_FIELDS-1:0][VALUE_W-1:0]   values;
      logic                                 digits;
      logic                                 negative;
      logic                                 stopped;
      logic                                 overflow;
   } csi_state_type;

   function automatic logic [VALUE_W-1:0] close_value(
      input logic [VALUE_W-1:0] mag,
      input logic               digits,
      input logic               negative,
      input logic               overflow
   );
      logic [VALUE_W-1:0] v;
      if (!digits || overflow) begin
         v = '0;
      end else if (negative) begin
         v = '0 - mag;
      end else begin
         v = mag;
      end
      return v;
   endfunction

   function automatic logic [4:0] cursor_key(input logic [7:0] c);
      logic [4:0] k;
      case (c)
         CH_UP_A: k = KEY_UP;
         CH_UP_B: k = KEY_DOWN;
         CH_UP_C: k = KEY_RIGHT;
         CH_UP_D: k = KEY_LEFT;
         CH_UP_H: k = KEY_HOME;
         CH_UP_F: k = KEY_END;
         default: k = KEY_UNKNOWN;
      endcase
      return k;
   endfunction

   function automatic logic [4:0] tilde_key(input logic signed [VALUE_W-1:0] p);
      logic [4:0] k;
      case (p)
         32'sd1:  k = KEY_HOME;
         32'sd2:  k = KEY_INSERT;
         32'sd3:  k = KEY_DELETE;
         32'sd4:  k = KEY_END;
         32'sd5:  k = KEY_PGUP;
         32'sd6:  k = KEY_PGDN;
         32'sd7:  k = KEY_HOME;
         32'sd8:  k = KEY_END;
         32'sd11: k = KEY_F1;
         32'sd12: k = KEY_F2;
         32'sd13: k = KEY_F3;
         32'sd14: k = KEY_F4;
         32'sd15: k = KEY_F5;
         32'sd17: k = KEY_F6;
         32'sd18: k = KEY_F7;
         32'sd19: k = KEY_F8;
         32'sd20: k = KEY_F9;
         32'sd21: k = KEY_F10;
         32'sd23: k = KEY_F11;
         32'sd24: k = KEY_F12;
         default: k = KEY_UNKNOWN;
      endcase
      return k;
   endfunction

endpackage

>>> rtl/csi_dec_parse.sv
// ----------------------------------------------------------------------------
// csi_dec_parse
// Parameter string parser: prefix, field split and per-field decimal
// accumulation with 32-bit range check.
// ----------------------------------------------------------------------------
module csi_dec_parse (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       take,
   input  logic                       clear,
   input  logic [7:0]                 char_byte,
   output csi_dec_pkg::csi_state_type state
);

   csi_dec_pkg::csi_state_type state_ff;
   csi_dec_pkg::csi_state_type state_in;

   logic [csi_dec_pkg::VALUE_W-1:0] open_mag;
   logic [35:0]                     mag_wide;
   logic [35:0]                     mag_next;
   logic [35:0]                     limit;
   logic [7:0]                      digit_byte;
   logic                            open_valid;

   always_comb begin
      case (state_ff.count)
         2'd0:    open_mag = state_ff.values[0];
         2'd1:    open_mag = state_ff.values[1];
         2'd2:    open_mag = state_ff.values[2];
         default: open_mag = '0;
      endcase
      open_valid = (state_ff.count != csi_dec_pkg::FIELD_CNT_MAX);
      digit_byte = char_byte - csi_dec_pkg::CH_ZERO;
      mag_wide   = {4'd0, open_mag};
      mag_next   = (mag_wide << 3) + (mag_wide << 1) + {32'd0, digit_byte[3:0]};
      limit      = state_ff.negative ? csi_dec_pkg::NEG_LIMIT : csi_dec_pkg::POS_LIMIT;
   end

   always_comb begin
      state_in = state_ff;
      if (clear) begin
         state_in = '0;
         state_in.pending = 1'b1;
      end else if (take) begin
         if (state_ff.pending) begin
            state_in.pending = 1'b0;
         end
         if (state_ff.pending && char_byte == csi_dec_pkg::CH_LT) begin
            state_in.prefix = csi_dec_pkg::PREFIX_LT;
         end else if (state_ff.pending && char_byte == csi_dec_pkg::CH_QM) begin
            state_in.prefix = csi_dec_pkg::PREFIX_QM;
         end else if (state_ff.pending && char_byte == csi_dec_pkg::CH_GT) begin
            state_in.prefix = csi_dec_pkg::PREFIX_GT;
         end else if (char_byte == csi_dec_pkg::CH_SEMI) begin
            for (int i = 0; i < csi_dec_pkg::NUM_FIELDS; i++) begin
               if (state_ff.count == 2'(i)) begin
                  state_in.values[i] = csi_dec_pkg::close_value(open_mag,
                     state_ff.digits, state_ff.negative, state_ff.overflow);
               end
            end
            if (open_valid) begin
               state_in.count = state_ff.count + 2'd1;
            end
            state_in.digits   = 1'b0;
            state_in.negative = 1'b0;
            state_in.stopped  = 1'b0;
            state_in.overflow = 1'b0;
         end else if (state_ff.stopped) begin
            state_in.stopped = 1'b1;
         end else if (char_byte inside {[csi_dec_pkg::CH_ZERO:csi_dec_pkg::CH_NINE]}) begin
            state_in.digits = 1'b1;
            if (!state_ff.overflow && open_valid) begin
               if (mag_next > limit) begin
                  state_in.overflow = 1'b1;
               end else begin
                  for (int i = 0; i < csi_dec_pkg::NUM_FIELDS; i++) begin
                     if (state_ff.count == 2'(i)) begin
                        state_in.values[i] = mag_next[csi_dec_pkg::VALUE_W-1:0];
                     end
                  end
               end
            end
         end else if (char_byte == csi_dec_pkg::CH_MINUS && !state_ff.digits
                      && !state_ff.negative) begin
            state_in.negative = 1'b1;
         end else begin
            state_in.stopped = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= '0;
         state_ff.pending <= 1'b1;
      end else begin
         state_ff <= state_in;
      end
   end

   assign state = state_ff;

   a_clear_restarts : assert property (@(posedge clock) disable iff (reset)
      clear |=> (state_ff.pending && state_ff.count == 2'd0 && state_ff.values == '0))
      else $error("parser not restarted after final byte");

   a_prefix_first_only : assert property (@(posedge clock) disable iff (reset)
      !state_ff.pending && !clear |=> state_ff.prefix == $past(state_ff.prefix))
      else $error("prefix changed after first byte");

endmodule

>>> rtl/csi_escape_sequence_decoder_top.sv
// ----------------------------------------------------------------------------
// csi_escape_sequence_decoder_top
// CSI parameter string decoder giving xterm key and SGR mouse events.
//
// The req channel carries one byte per beat; req_is_final marks the final
// byte of a sequence. Parameter beats update the parser registers and give
// no rsp beat. The final beat gives exactly one rsp beat holding the event,
// registered in the cycle after acceptance, and restarts the parser for the
// next sequence. Each byte updates the parser registers, and the event is
// decoded combinationally from them and the final byte; a beat is accepted
// in every cycle while the rsp register is empty or being drained (1 byte/cycle).
// When the receiver stalls, the event holds in the rsp register and req_ready
// drops, so no further byte is accepted until that event is taken.
// Reset clears the parser to its start state and empties the rsp register;
// req_ready is low while reset is high.
// ----------------------------------------------------------------------------
module csi_escape_sequence_decoder_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_char_byte,
   input  logic        req_is_final,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_event_kind,
   output logic [4:0]  rsp_key_code,
   output logic [3:0]  rsp_modifier_bits,
   output logic [15:0] rsp_mouse_x,
   output logic [15:0] rsp_mouse_y,
   output logic [7:0]  rsp_mouse_button,
   output logic [1:0]  rsp_mouse_action
);

   csi_dec_pkg::csi_state_type st;

   logic        accept;
   logic        take;
   logic        clear;
   logic [31:0] open_mag;
   logic [31:0] closed;
   logic [31:0] v0;
   logic [31:0] v1;
   logic [31:0] v2;
   logic [31:0] p1_dec;
   logic [31:0] p2_dec;
   logic        cnt_ge1;
   logic        cnt_ge2;
   logic        cnt_ge3;
   logic        is_mouse;

   logic        rsp_valid_ff;
   logic        event_kind_ff, event_kind_in;
   logic [4:0]  key_code_ff, key_code_in;
   logic [3:0]  modifier_bits_ff, modifier_bits_in;
   logic [15:0] mouse_x_ff, mouse_x_in;
   logic [15:0] mouse_y_ff, mouse_y_in;
   logic [7:0]  mouse_button_ff, mouse_button_in;
   logic [1:0]  mouse_action_ff, mouse_action_in;

   assign req_ready = !reset && (!rsp_valid_ff || rsp_ready);
   assign accept    = req_valid && req_ready;
   assign take      = accept && !req_is_final;
   assign clear     = accept && req_is_final;

   csi_dec_parse u_parse (
      .clock     (clock),
      .reset     (reset),
      .take      (take),
      .clear     (clear),
      .char_byte (req_char_byte),
      .state     (st)
   );

   always_comb begin
      case (st.count)
         2'd0:    open_mag = st.values[0];
         2'd1:    open_mag = st.values[1];
         2'd2:    open_mag = st.values[2];
         default: open_mag = '0;
      endcase
      closed = csi_dec_pkg::close_value(open_mag, st.digits, st.negative, st.overflow);

      cnt_ge1 = !st.pending;
      cnt_ge2 = !st.pending && st.count >= 2'd1;
      cnt_ge3 = !st.pending && st.count >= 2'd2;

      v0 = !cnt_ge1 ? '0 : (st.count == 2'd0) ? closed : st.values[0];
      v1 = !cnt_ge2 ? '0 : (st.count == 2'd1) ? closed : st.values[1];
      v2 = !cnt_ge3 ? '0 : (st.count == 2'd2) ? closed : st.values[2];

      p1_dec = v1 - 32'd1;
      p2_dec = v2 - 32'd1;

      is_mouse = st.prefix == csi_dec_pkg::PREFIX_LT && cnt_ge3
                 && (req_char_byte == csi_dec_pkg::CH_UP_M
                     || req_char_byte == csi_dec_pkg::CH_LO_M);

      event_kind_in    = csi_dec_pkg::EVT_KEY;
      key_code_in      = csi_dec_pkg::KEY_UNKNOWN;
      modifier_bits_in = '0;
      mouse_x_in       = '0;
      mouse_y_in       = '0;
      mouse_button_in  = '0;
      mouse_action_in  = csi_dec_pkg::ACT_PRESS;

      if (cnt_ge2 && $signed(v1) > 32'sd1) begin
         modifier_bits_in = p1_dec[3:0];
      end

      if (is_mouse) begin
         event_kind_in    = csi_dec_pkg::EVT_MOUSE;
         mouse_x_in       = ($signed(v1) > 32'sd0) ? p1_dec[15:0] : 16'd0;
         mouse_y_in       = ($signed(v2) > 32'sd0) ? p2_dec[15:0] : 16'd0;
         modifier_bits_in = {1'b0, v0[4], v0[3], v0[2]};
         mouse_button_in  = v0[7:0] & ~csi_dec_pkg::MOUSE_MOD_MASK;
         if (req_char_byte == csi_dec_pkg::CH_LO_M) begin
            mouse_action_in = csi_dec_pkg::ACT_RELEASE;
         end else if (v0[5]) begin
            mouse_action_in = csi_dec_pkg::ACT_DRAG;
         end
      end else if (req_char_byte inside {[csi_dec_pkg::CH_UP_A:csi_dec_pkg::CH_UP_H]}) begin
         key_code_in = csi_dec_pkg::cursor_key(req_char_byte);
      end else if (req_char_byte == csi_dec_pkg::CH_TILDE && cnt_ge1) begin
         key_code_in = csi_dec_pkg::tilde_key($signed(v0));
      end else begin
         modifier_bits_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (clear) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (clear) begin
         event_kind_ff    <= event_kind_in;
         key_code_ff      <= key_code_in;
         modifier_bits_ff <= modifier_bits_in;
         mouse_x_ff       <= mouse_x_in;
         mouse_y_ff       <= mouse_y_in;
         mouse_button_ff  <= mouse_button_in;
         mouse_action_ff  <= mouse_action_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_event_kind    = event_kind_ff;
   assign rsp_key_code      = key_code_ff;
   assign rsp_modifier_bits = modifier_bits_ff;
   assign rsp_mouse_x       = mouse_x_ff;
   assign rsp_mouse_y       = mouse_y_ff;
   assign rsp_mouse_button  = mouse_button_ff;
   assign rsp_mouse_action  = mouse_action_ff;

   a_final_gives_event : assert property (@(posedge clock) disable iff (reset)
      clear |=> rsp_valid_ff)
      else $error("final byte did not produce an event");

   a_event_from_final : assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(clear))
      else $error("event raised without a final byte");

   a_mouse_no_key : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && event_kind_ff == csi_dec_pkg::EVT_MOUSE
      |-> key_code_ff == csi_dec_pkg::KEY_UNKNOWN && !modifier_bits_ff[3])
      else $error("mouse event carries key fields");

   a_key_no_mouse : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && event_kind_ff == csi_dec_pkg::EVT_KEY
      |-> mouse_x_ff == 16'd0 && mouse_y_ff == 16'd0 && mouse_button_ff == 8'd0
          && mouse_action_ff == csi_dec_pkg::ACT_PRESS)
      else $error("key event carries mouse fields");

endmodule

>>> bench/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the CSI escape sequence decoder.
//
// A queue of byte beats (directed sequences first, then random mouse reports,
// cursor keys, editing keys and noise) feeds a valid/ready driver. Every
// accepted beat runs through a local parser that predicts the event each
// final byte produces; a monitor compares every rsp beat with the oldest
// predicted event. Both sides idle at random, and the receiver holds off for
// long stretches so that the decoder backs up and stalls its input.
// ----------------------------------------------------------------------------
module testbench;

   typedef struct packed {
      logic [7:0] ch;
      logic       fin;
   } csi_beat_type;

   typedef struct packed {
      logic        kind;
      logic [4:0]  key;
      logic [3:0]  mods;
      logic [15:0] mx;
      logic [15:0] my;
      logic [7:0]  btn;
      logic [1:0]  act;
   } csi_event_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [7:0]  req_char_byte = 8'h00;
   logic        req_is_final = 1'b0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic        rsp_event_kind;
   logic [4:0]  rsp_key_code;
   logic [3:0]  rsp_modifier_bits;
   logic [15:0] rsp_mouse_x;
   logic [15:0] rsp_mouse_y;
   logic [7:0]  rsp_mouse_button;
   logic [1:0]  rsp_mouse_action;

   csi_beat_type  byte_queue[$];
   csi_event_type pending_events[$];

   // parser state mirrored for prediction
   logic        parse_pending;
   logic [1:0]  parse_prefix;
   logic [1:0]  parse_count;
   logic [31:0] parse_val [3];
   logic        parse_digits;
   logic        parse_neg;
   logic        parse_stop;
   logic        parse_ovf;

   int            errors = 0;
   int            beats_sent = 0;
   int            beats_total = 0;
   int            events_seen = 0;
   int            mouse_seen = 0;
   int            send_gap = 0;
   bit            send_eager = 1'b0;
   int            recv_stall = 0;
   bit            recv_eager = 1'b0;
   int            hold_left = 0;
   int            holds_done = 0;
   csi_beat_type  next_beat;
   csi_event_type want_event;
   csi_event_type got_event;

   csi_escape_sequence_decoder_top i_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_char_byte     (req_char_byte),
      .req_is_final      (req_is_final),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_event_kind    (rsp_event_kind),
      .rsp_key_code      (rsp_key_code),
      .rsp_modifier_bits (rsp_modifier_bits),
      .rsp_mouse_x       (rsp_mouse_x),
      .rsp_mouse_y       (rsp_mouse_y),
      .rsp_mouse_button  (rsp_mouse_button),
      .rsp_mouse_action  (rsp_mouse_action)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 0;
   end

   task automatic restart_parse();
      parse_pending = 1'b1;
      parse_prefix  = csi_dec_pkg::PREFIX_NONE;
      parse_count   = 2'd0;
      parse_val[0]  = '0;
      parse_val[1]  = '0;
      parse_val[2]  = '0;
      parse_digits  = 1'b0;
      parse_neg     = 1'b0;
      parse_stop    = 1'b0;
      parse_ovf     = 1'b0;
   endtask

   task automatic seal_field();
      if (parse_count < csi_dec_pkg::FIELD_CNT_MAX) begin
         if (!parse_digits || parse_ovf) begin
            parse_val[parse_count] = '0;
         end else if (parse_neg) begin
            parse_val[parse_count] = '0 - parse_val[parse_count];
         end
      end
   endtask

   function automatic logic [4:0] edit_key_for(input int code);
      case (code)
         1, 7:    return csi_dec_pkg::KEY_HOME;
         2:       return csi_dec_pkg::KEY_INSERT;
         3:       return csi_dec_pkg::KEY_DELETE;
         4, 8:    return csi_dec_pkg::KEY_END;
         5:       return csi_dec_pkg::KEY_PGUP;
         6:       return csi_dec_pkg::KEY_PGDN;
         11:      return csi_dec_pkg::KEY_F1;
         12:      return csi_dec_pkg::KEY_F2;
         13:      return csi_dec_pkg::KEY_F3;
         14:      return csi_dec_pkg::KEY_F4;
         15:      return csi_dec_pkg::KEY_F5;
         17:      return csi_dec_pkg::KEY_F6;
         18:      return csi_dec_pkg::KEY_F7;
         19:      return csi_dec_pkg::KEY_F8;
         20:      return csi_dec_pkg::KEY_F9;
         21:      return csi_dec_pkg::KEY_F10;
         23:      return csi_dec_pkg::KEY_F11;
         24:      return csi_dec_pkg::KEY_F12;
         default: return csi_dec_pkg::KEY_UNKNOWN;
      endcase
   endfunction

   task automatic track_csi_byte(input logic [7:0] c, input logic fin);
      logic [63:0]   grown;
      int            n;
      int            a0;
      int            a1;
      int            a2;
      int            less_one;
      logic [31:0]   code;
      csi_event_type ev;
      if (!fin) begin
         if (parse_pending) begin
            parse_pending = 1'b0;
            if (c == csi_dec_pkg::CH_LT) begin
               parse_prefix = csi_dec_pkg::PREFIX_LT;
               return;
            end
            if (c == csi_dec_pkg::CH_QM) begin
               parse_prefix = csi_dec_pkg::PREFIX_QM;
               return;
            end
            if (c == csi_dec_pkg::CH_GT) begin
               parse_prefix = csi_dec_pkg::PREFIX_GT;
               return;
            end
         end
         if (c == csi_dec_pkg::CH_SEMI) begin
            seal_field();
            if (parse_count < csi_dec_pkg::FIELD_CNT_MAX) parse_count++;
            parse_digits = 1'b0;
            parse_neg    = 1'b0;
            parse_stop   = 1'b0;
            parse_ovf    = 1'b0;
            return;
         end
         if (parse_stop) return;
         if (c >= csi_dec_pkg::CH_ZERO && c <= csi_dec_pkg::CH_NINE) begin
            parse_digits = 1'b1;
            if (!parse_ovf && parse_count < csi_dec_pkg::FIELD_CNT_MAX) begin
               grown = parse_val[parse_count] * 64'd10 + (c - csi_dec_pkg::CH_ZERO);
               if (grown > (parse_neg ? csi_dec_pkg::NEG_LIMIT
                                      : csi_dec_pkg::POS_LIMIT)) begin
                  parse_ovf = 1'b1;
               end else begin
                  parse_val[parse_count] = grown[31:0];
               end
            end
         end else if (c == csi_dec_pkg::CH_MINUS && !parse_digits && !parse_neg) begin
            parse_neg = 1'b1;
         end else begin
            parse_stop = 1'b1;
         end
         return;
      end

      ev = '0;
      if (parse_pending) begin
         n = 0;
      end else begin
         seal_field();
         n = (parse_count == csi_dec_pkg::FIELD_CNT_MAX) ? 3 : parse_count + 1;
      end
      a0 = (n >= 1) ? parse_val[0] : 0;
      a1 = (n >= 2) ? parse_val[1] : 0;
      a2 = (n >= 3) ? parse_val[2] : 0;
      less_one = a1 - 1;
      if (n >= 2 && a1 > 1) ev.mods = less_one[3:0];

      if (parse_prefix == csi_dec_pkg::PREFIX_LT && n >= 3
          && (c == csi_dec_pkg::CH_UP_M || c == csi_dec_pkg::CH_LO_M)) begin
         code    = parse_val[0];
         ev.kind = csi_dec_pkg::EVT_MOUSE;
         ev.mx   = (a1 > 0) ? less_one[15:0] : '0;
         less_one = a2 - 1;
         ev.my   = (a2 > 0) ? less_one[15:0] : '0;
         ev.act  = (c == csi_dec_pkg::CH_LO_M) ? csi_dec_pkg::ACT_RELEASE :
                   (code[5] ? csi_dec_pkg::ACT_DRAG : csi_dec_pkg::ACT_PRESS);
         ev.mods = {1'b0, code[4], code[3], code[2]};
         ev.btn  = code[7:0] & ~csi_dec_pkg::MOUSE_MOD_MASK;
      end else if (c >= csi_dec_pkg::CH_UP_A && c <= csi_dec_pkg::CH_UP_H) begin
         case (c)
            csi_dec_pkg::CH_UP_A: ev.key = csi_dec_pkg::KEY_UP;
            csi_dec_pkg::CH_UP_B: ev.key = csi_dec_pkg::KEY_DOWN;
            csi_dec_pkg::CH_UP_C: ev.key = csi_dec_pkg::KEY_RIGHT;
            csi_dec_pkg::CH_UP_D: ev.key = csi_dec_pkg::KEY_LEFT;
            csi_dec_pkg::CH_UP_H: ev.key = csi_dec_pkg::KEY_HOME;
            csi_dec_pkg::CH_UP_F: ev.key = csi_dec_pkg::KEY_END;
            default:              ev.key = csi_dec_pkg::KEY_UNKNOWN;
         endcase
      end else if (c == csi_dec_pkg::CH_TILDE && n >= 1) begin
         ev.key = edit_key_for(a0);
      end else begin
         ev.mods = '0;
      end
      pending_events.insert(pending_events.size(), ev);
      restart_parse();
   endtask

   task automatic queue_beat(input logic [7:0] c, input logic fin);
      csi_beat_type beat;
      beat.ch  = c;
      beat.fin = fin;
      byte_queue.insert(byte_queue.size(), beat);
   endtask

   task automatic queue_sequence(input string params, input logic [7:0] end_byte);
      int i;
      for (i = 0; i < params.len(); i++) queue_beat(params[i], 1'b0);
      queue_beat(end_byte, 1'b1);
   endtask

   function automatic string number_text();
      case ($urandom_range(0, 9))
         0:       return "";
         1:       return $sformatf("-%0d", $urandom_range(0, 300));
         2:       return $sformatf("%0d", 64'd2147483640 + $urandom_range(0, 15));
         3:       return $sformatf("-%0d", 64'd2147483640 + $urandom_range(0, 15));
         4:       return $sformatf("%0d", $urandom);
         5:       return $sformatf("00%0d", $urandom_range(0, 99));
         default: return $sformatf("%0d", $urandom_range(0, 300));
      endcase
   endfunction

   function automatic string coord_text();
      if ($urandom_range(0, 4) == 0) return number_text();
      return $sformatf("%0d", $urandom_range(1, 300));
   endfunction

   function automatic logic [7:0] noise_byte();
      case ($urandom_range(0, 7))
         0, 1, 2: return 8'(csi_dec_pkg::CH_ZERO + $urandom_range(0, 9));
         3:       return csi_dec_pkg::CH_SEMI;
         4:       return csi_dec_pkg::CH_MINUS;
         5:       return ($urandom_range(0, 2) == 0) ? csi_dec_pkg::CH_LT :
                         (($urandom_range(0, 1) == 0) ? csi_dec_pkg::CH_QM
                                                      : csi_dec_pkg::CH_GT);
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   function automatic logic [7:0] noise_end_byte();
      case ($urandom_range(0, 5))
         0:       return 8'(csi_dec_pkg::CH_UP_A + $urandom_range(0, 7));
         1:       return csi_dec_pkg::CH_TILDE;
         2:       return $urandom_range(0, 1) ? csi_dec_pkg::CH_UP_M : csi_dec_pkg::CH_LO_M;
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            track_csi_byte(req_char_byte, req_is_final);
            beats_sent++;
         end
         if (!req_valid || req_ready) begin
            if (send_gap > 0) begin
               send_gap--;
               req_valid <= 1'b0;
            end else if (byte_queue.size() > 0) begin
               next_beat = byte_queue.pop_front();
               req_valid     <= 1'b1;
               req_char_byte <= next_beat.ch;
               req_is_final  <= next_beat.fin;
               if ($urandom_range(0, 99) == 0) send_eager = !send_eager;
               send_gap = send_eager ? 0 : pick_gap();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // long receiver hold-off, so the decoder backs up and drops req_ready
   always @(posedge clock) begin
      if (reset) begin
         hold_left <= 0;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
      end else if (holds_done < 2 && events_seen >= 30 + 90 * holds_done) begin
         hold_left  <= 250;
         holds_done <= holds_done + 1;
      end
   end

   // monitor
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            got_event = {rsp_event_kind, rsp_key_code, rsp_modifier_bits, rsp_mouse_x,
                         rsp_mouse_y, rsp_mouse_button, rsp_mouse_action};
            if (pending_events.size() == 0) begin
               errors++;
               if (errors <= 10)
                  $display("ERROR: rsp beat with no event pending: kind=%0d key=%0d",
                           got_event.kind, got_event.key);
            end else begin
               want_event = pending_events.pop_front();
               events_seen++;
               if (want_event.kind == csi_dec_pkg::EVT_MOUSE) mouse_seen++;
               if (got_event !== want_event) begin
                  errors++;
                  if (errors <= 10) begin
                     $display({"ERROR: event %0d expected kind=%0d key=%0d mods=%h",
                               " x=%0d y=%0d btn=%h act=%0d"},
                              events_seen, want_event.kind, want_event.key, want_event.mods,
                              want_event.mx, want_event.my, want_event.btn, want_event.act);
                     $display({"       got      kind=%0d key=%0d mods=%h",
                               " x=%0d y=%0d btn=%h act=%0d"},
                              got_event.kind, got_event.key, got_event.mods, got_event.mx,
                              got_event.my, got_event.btn, got_event.act);
                  end
               end
            end
         end
         if (recv_stall > 0) begin
            recv_stall--;
         end else if (!recv_eager) begin
            recv_stall = pick_gap();
         end
         if ($urandom_range(0, 149) == 0) recv_eager = !recv_eager;
         rsp_ready <= (recv_stall == 0) && (hold_left == 0);
      end
   end

   initial begin
      #5_000_000;
      $display("ERROR: run timed out");
      $display("testbench: FAIL");
      $finish;
   end

   initial begin
      string text;
      int    pick;
      int    len;
      restart_parse();

      queue_sequence("", csi_dec_pkg::CH_UP_A);
      queue_sequence("1;5", csi_dec_pkg::CH_UP_C);
      queue_sequence("1;0", csi_dec_pkg::CH_UP_D);
      queue_sequence("1;-3", csi_dec_pkg::CH_UP_B);
      queue_sequence("1;9", 8'h47);
      queue_sequence("<0;1;1", csi_dec_pkg::CH_UP_M);
      queue_sequence("<60;0;-3", csi_dec_pkg::CH_UP_M);
      queue_sequence("<35;80;24", csi_dec_pkg::CH_UP_M);
      queue_sequence("<2;10;5", csi_dec_pkg::CH_LO_M);
      queue_sequence("<65535;65537;1", csi_dec_pkg::CH_LO_M);
      queue_sequence("<0;5", csi_dec_pkg::CH_UP_M);
      queue_sequence("3", csi_dec_pkg::CH_TILDE);
      queue_sequence("24;3", csi_dec_pkg::CH_TILDE);
      queue_sequence(";", csi_dec_pkg::CH_TILDE);
      queue_sequence("2147483647;2", csi_dec_pkg::CH_TILDE);
      queue_sequence("-2147483648", csi_dec_pkg::CH_TILDE);
      queue_sequence("2147483648;4", csi_dec_pkg::CH_TILDE);
      queue_sequence("-2147483649;3;9;11", csi_dec_pkg::CH_TILDE);
      queue_sequence("--5", csi_dec_pkg::CH_TILDE);
      queue_sequence("?1;2<3", csi_dec_pkg::CH_UP_H);
      queue_sequence(">1;2", 8'h63);
      queue_sequence("15;6", 8'h35);
      queue_beat(8'hFF, 1'b0);
      queue_beat(csi_dec_pkg::CH_SEMI, 1'b0);
      queue_beat(8'h00, 1'b1);
      queue_beat(8'hFF, 1'b1);

      while (byte_queue.size() < 1100) begin
         pick = $urandom_range(0, 99);
         if (pick < 35) begin
            text = ($urandom_range(0, 5) == 0) ? number_text()
                                               : $sformatf("%0d", $urandom_range(0, 255));
            text = {"<", text, ";", coord_text()};
            if ($urandom_range(0, 9) != 0) text = {text, ";", coord_text()};
            if ($urandom_range(0, 5) == 0) text = {text, ";", number_text()};
            queue_sequence(text, $urandom_range(0, 1) ? csi_dec_pkg::CH_UP_M
                                                      : csi_dec_pkg::CH_LO_M);
         end else if (pick < 55) begin
            text = "";
            if ($urandom_range(0, 2) != 0)
               text = $sformatf("1;%0d", $urandom_range(0, 17));
            queue_sequence(text, 8'(csi_dec_pkg::CH_UP_A + $urandom_range(0, 7)));
         end else if (pick < 75) begin
            text = $sformatf("%0d", $urandom_range(0, 26));
            if ($urandom_range(0, 1) != 0)
               text = {text, ";", $sformatf("%0d", $urandom_range(0, 17))};
            if ($urandom_range(0, 7) == 0) text = number_text();
            queue_sequence(text, csi_dec_pkg::CH_TILDE);
         end else begin
            len = $urandom_range(0, 8);
            repeat (len) queue_beat(noise_byte(), 1'b0);
            queue_beat(noise_end_byte(), 1'b1);
         end
      end
      beats_total = byte_queue.size();

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      while (beats_sent < beats_total || pending_events.size() != 0)
         @(posedge clock);
      repeat (20) @(posedge clock);

      if (pending_events.size() != 0) begin
         $display("ERROR: %0d predicted events never arrived", pending_events.size());
         errors += pending_events.size();
      end
      $display("covered %0d byte beats and %0d events (%0d mouse, %0d key)",
               beats_sent, events_seen, mouse_seen, events_seen - mouse_seen);
      $display("receiver held off %0d times; %0d mismatches", holds_done, errors);
      if (errors == 0) begin
         $display("testbench: PASS");
      end else begin
         $display("testbench: FAIL");
      end
      $finish;
   end

endmodule

>>> csi_escape_sequence_decoder_top.f
rtl/csi_dec_pkg.sv
rtl/csi_dec_parse.sv
rtl/csi_escape_sequence_decoder_top.sv
bench/testbench.sv
